FILE: hw/rtl/cadc_pkg.sv
`default_nettype none

package cadc_pkg;

    // Shared multiplier operand width, wide enough for the 22-bit gain-scale product.
    localparam int MUL_W = 24;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Register field widths.
    localparam int REG_GAIN_W   = 12;
    localparam int GAIN_W       = 10;
    localparam int SCALE_W      = 12;
    localparam int THRESH_W     = 15;
    localparam int GS_W         = GAIN_W + SCALE_W;

    // Gain clamp limits, Q4.8 (0.5 and 2.5).
    localparam logic [REG_GAIN_W-1:0] GAIN_LO = 12'd128;
    localparam logic [REG_GAIN_W-1:0] GAIN_HI = 12'd640;

    // Division by five as a multiply by floor(2^22 / 5) plus one correction step.
    localparam int             DIV5_SHIFT = 22;
    localparam logic [19:0]    DIV5_RECIP = 20'd838860;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAMP_GAIN  = 3'd0,
        CFG_MIST_GAIN  = 3'd1,
        CFG_LAMP_SCALE = 3'd2,
        CFG_MIST_SCALE = 3'd3,
        CFG_CO2_ON     = 3'd4,
        CFG_CO2_OFF    = 3'd5
    } cadc_cfg_idx_t;

    // Sequencer states, one multiplier pass in each state from ST_DIV to ST_MP.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LGS,
        ST_LP,
        ST_NOTC,
        ST_MGS,
        ST_MP,
        ST_DONE
    } cadc_state_t;

    // Configuration as seen by the datapath, gains already clamped.
    typedef struct packed {
        logic [GAIN_W-1:0]   lamp_gain;
        logic [GAIN_W-1:0]   mist_gain;
        logic [SCALE_W-1:0]  lamp_scale;
        logic [SCALE_W-1:0]  mist_scale;
        logic [THRESH_W-1:0] co2_on;
        logic [THRESH_W-1:0] co2_off;
    } cadc_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cadc_cfg.sv
`default_nettype none

module cadc_cfg
    import cadc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cadc_cfg_t                  cfg
);

    logic [REG_GAIN_W-1:0] lamp_gain_reg;
    logic [REG_GAIN_W-1:0] mist_gain_reg;
    logic [SCALE_W-1:0]    lamp_scale_reg;
    logic [SCALE_W-1:0]    mist_scale_reg;
    logic [THRESH_W-1:0]   co2_on_reg;
    logic [THRESH_W-1:0]   co2_off_reg;

    // The register file takes a write in every cycle.
    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_gain_reg  <= 12'd256;
            mist_gain_reg  <= 12'd256;
            lamp_scale_reg <= 12'd256;
            mist_scale_reg <= 12'd256;
            co2_on_reg     <= 15'd50;
            co2_off_reg    <= 15'd20;
        end
        else if (cfg_valid)
        begin
            unique case (cadc_cfg_idx_t'(cfg_index))
                CFG_LAMP_GAIN:  lamp_gain_reg  <= cfg_data[REG_GAIN_W-1:0];
                CFG_MIST_GAIN:  mist_gain_reg  <= cfg_data[REG_GAIN_W-1:0];
                CFG_LAMP_SCALE: lamp_scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_MIST_SCALE: mist_scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_CO2_ON:     co2_on_reg     <= cfg_data[THRESH_W-1:0];
                CFG_CO2_OFF:    co2_off_reg    <= cfg_data[THRESH_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamp a Q4.8 gain to 0.5..2.5.
    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [REG_GAIN_W-1:0] g);
        logic [REG_GAIN_W-1:0] c;
        begin
            if (g < GAIN_LO)
                c = GAIN_LO;
            else if (g > GAIN_HI)
                c = GAIN_HI;
            else
                c = g;
            return c[GAIN_W-1:0];
        end
    endfunction

    always_comb
    begin
        cfg.lamp_gain  = clamp_gain(lamp_gain_reg);
        cfg.mist_gain  = clamp_gain(mist_gain_reg);
        cfg.lamp_scale = lamp_scale_reg;
        cfg.mist_scale = mist_scale_reg;
        cfg.co2_on     = co2_on_reg;
        cfg.co2_off    = co2_off_reg;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cadc_mul.sv
`default_nettype none

module cadc_mul
    import cadc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [MUL_W-1:0]   op_a,
    input  wire logic [MUL_W-1:0]   op_b,
    output logic [2*MUL_W-1:0]      prod
);

    logic [2*MUL_W-1:0] prod_reg;

    // One registered multiply per enabled cycle; the product holds otherwise.
    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/climate_actuator_demand_controller_top.sv
`default_nettype none

// Channel  Handshake             Payload
// -------  --------------------  -----------------------------------------------------
// in       in_valid / in_ready   temp_error, temp_ok, humid_error, humid_ok,
//                                co2_error, co2_ok
// out      out_valid / out_ready lamp_demand, mist_demand, exhaust_demand, co2_exhaust_on
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// An item goes through six passes through the one shared multiplier (ST_DIV to ST_MP)
// and a final assembly step (ST_DONE) before its result enters the output register; the
// block does not accept the next item until the sequencer is back in ST_IDLE.
// Reset clears the sequencer, the output valid flag and the CO2 latch and restores the
// register defaults. A result that is not taken holds the output register; the next
// item may still be accepted, and the sequencer waits in its last step until the
// output register is free.
module climate_actuator_demand_controller_top
    import cadc_pkg::*;
#(
    parameter int DEMAND_FRAC_BITS = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [15:0]    temp_error,
    input  wire logic                  temp_ok,
    input  wire logic signed [15:0]    humid_error,
    input  wire logic                  humid_ok,
    input  wire logic signed [15:0]    co2_error,
    input  wire logic                  co2_ok,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [10:0]                lamp_demand,
    output logic [10:0]                mist_demand,
    output logic [10:0]                exhaust_demand,
    output logic                       co2_exhaust_on,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int F  = DEMAND_FRAC_BITS;
    localparam int DW = F + 1;
    localparam int XW = F + 3;
    localparam int OW = 11;
    localparam logic [DW-1:0] FULL = DW'(1) << F;
    localparam logic [OW+DW-1:0] FULL_WIDE = (OW+DW)'(FULL);
    localparam logic [OW-1:0] FULL_OUT = FULL_WIDE[OW-1:0];

    cadc_cfg_t          cfg;
    cadc_state_t        state_reg;
    cadc_state_t        state_next;

    logic               mul_en;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] prod;

    // Per-item working registers.
    logic [DW-1:0]      cold_reg;
    logic [DW-1:0]      hot_reg;
    logic [XW-1:0]      x_reg;
    logic               hsat_reg;
    logic               hpos_reg;
    logic               hneg_reg;
    logic               ok_reg;
    logic [DW-1:0]      memb_reg;
    logic [DW-1:0]      lamp_reg;
    logic [DW-1:0]      hmix_reg;
    logic               co2_latch_reg;
    logic               co2_latch_next;

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [OW-1:0]      lamp_out_reg;
    logic [OW-1:0]      mist_out_reg;
    logic [OW-1:0]      exh_out_reg;
    logic               co2_out_reg;

    logic               accept;
    logic               out_load;

    cadc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cadc_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Temperature ramp: magnitude, saturation at 4 degC, and scaling to Q0.F.
    logic [16:0]   te_u;
    logic [16:0]   tmag;
    logic          tsat;
    logic [F+9:0]  tsh;
    logic [DW-1:0] tramp;
    logic          tpos;

    always_comb
    begin
        te_u  = {temp_error[15], temp_error};
        tmag  = te_u[16] ? (~te_u + 17'd1) : te_u;
        tsat  = (tmag >= 17'd1024);
        tsh   = {tmag[9:0], {F{1'b0}}};
        tramp = tsat ? FULL : {1'b0, tsh[F+9:10]};
        tpos  = !temp_error[15] && (temp_error != 16'sd0);
    end

    // Humidity ramp: the dividend before the division by five, and saturation at 20 %RH.
    logic [16:0]   he_u;
    logic [16:0]   hmag;
    logic          hsat;
    logic [F+12:0] hsh;

    always_comb
    begin
        he_u = {humid_error[15], humid_error};
        hmag = he_u[16] ? (~he_u + 17'd1) : he_u;
        hsat = (hmag >= 17'd5120);
        hsh  = {hmag[12:0], {F{1'b0}}};
    end

    // CO2 hysteresis latch, updated when the sample is accepted.
    logic signed [16:0] excess;
    logic signed [16:0] on_thr;
    logic signed [16:0] off_thr;

    always_comb
    begin
        excess  = -$signed({co2_error[15], co2_error});
        on_thr  = $signed({2'b00, cfg.co2_on});
        off_thr = $signed({2'b00, cfg.co2_off});
        co2_latch_next = co2_latch_reg;
        if (accept)
        begin
            if (!co2_ok)
                co2_latch_next = 1'b0;
            else if (!co2_latch_reg)
            begin
                if (excess > on_thr)
                    co2_latch_next = 1'b1;
            end
            else if (excess < off_thr)
                co2_latch_next = 1'b0;
        end
    end

    // Division by five: correct the reciprocal estimate by at most one.
    logic [DW-1:0]   q_est;
    logic [XW:0]     q_times5;
    logic [XW:0]     q_rem;
    logic [DW-1:0]   q_div;

    always_comb
    begin
        q_est    = prod[DIV5_SHIFT +: DW];
        q_times5 = {(XW+1-DW)'(0), q_est} + {(XW-1-DW)'(0), q_est, 2'b00};
        q_rem    = {1'b0, x_reg} - q_times5;
        q_div    = (q_rem >= (XW+1)'(5)) ? (q_est + DW'(1)) : q_est;
    end

    // Gain stage results, shifted by the two Q4.8 factors and saturated.
    logic [31:0]   gain_prod;
    logic [DW-1:0] gain_sat;
    logic [DW-1:0] notcold;
    logic [DW-1:0] mist_raw;
    logic [DW-1:0] hum_exh;
    logic [DW-1:0] exh_th;
    logic [DW-1:0] exh_all;
    logic [DW-1:0] lamp_fin;
    logic [DW-1:0] mist_fin;

    always_comb
    begin
        gain_prod = prod[47:16];
        gain_sat  = (gain_prod > 32'(FULL)) ? FULL : gain_prod[DW-1:0];
        notcold   = FULL - cold_reg;
        mist_raw  = hpos_reg ? hmix_reg : '0;
        hum_exh   = hneg_reg ? hmix_reg : '0;
        exh_th    = (hot_reg > hum_exh) ? hot_reg : hum_exh;
        if (!ok_reg)
            exh_th = '0;
        exh_all   = (co2_latch_reg && (FULL > exh_th)) ? FULL : exh_th;
        lamp_fin  = ok_reg ? lamp_reg : '0;
        mist_fin  = ok_reg ? gain_sat : '0;
    end

    // Sequencer: next state and multiplier operands.
    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(x_reg);
                mul_b      = MUL_W'(DIV5_RECIP);
                state_next = ST_LGS;
            end
            ST_LGS:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(cfg.lamp_gain);
                mul_b      = MUL_W'(cfg.lamp_scale);
                state_next = ST_LP;
            end
            ST_LP:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(cold_reg);
                mul_b      = MUL_W'(prod[GS_W-1:0]);
                state_next = ST_NOTC;
            end
            ST_NOTC:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(memb_reg);
                mul_b      = MUL_W'(notcold);
                state_next = ST_MGS;
            end
            ST_MGS:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(cfg.mist_gain);
                mul_b      = MUL_W'(cfg.mist_scale);
                state_next = ST_MP;
            end
            ST_MP:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(mist_raw);
                mul_b      = MUL_W'(prod[GS_W-1:0]);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && !out_ready;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            co2_latch_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            co2_latch_reg <= co2_latch_next;
        end
    end

    // Working registers, loaded at the step that produces each value.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cold_reg <= tpos ? tramp : '0;
            hot_reg  <= temp_error[15] ? tramp : '0;
            x_reg    <= hsh[F+12:10];
            hsat_reg <= hsat;
            hpos_reg <= !humid_error[15] && (humid_error != 16'sd0);
            hneg_reg <= humid_error[15];
            ok_reg   <= temp_ok && humid_ok;
        end
        if (state_reg == ST_LGS)
            memb_reg <= hsat_reg ? FULL : q_div;
        if (state_reg == ST_NOTC)
            lamp_reg <= gain_sat;
        if (state_reg == ST_MGS)
            hmix_reg <= prod[F +: DW];
    end

    // Output register; the result is widened or cut to the 11-bit ports.
    logic [OW+DW-1:0] lamp_wide;
    logic [OW+DW-1:0] mist_wide;
    logic [OW+DW-1:0] exh_wide;

    always_comb
    begin
        lamp_wide = {{OW{1'b0}}, lamp_fin};
        mist_wide = {{OW{1'b0}}, mist_fin};
        exh_wide  = {{OW{1'b0}}, exh_all};
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            lamp_out_reg <= lamp_wide[OW-1:0];
            mist_out_reg <= mist_wide[OW-1:0];
            exh_out_reg  <= exh_wide[OW-1:0];
            co2_out_reg  <= co2_latch_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign lamp_demand    = lamp_out_reg;
    assign mist_demand    = mist_out_reg;
    assign exhaust_demand = exh_out_reg;
    assign co2_exhaust_on = co2_out_reg;

`ifndef ASSERT_OFF
    // A newly accepted beat keeps the input side closed in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted again right after an accept");

    // An invalid CO2 sample always leaves the latch released.
    a_co2_invalid_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !co2_ok) |=> !co2_latch_reg)
        else $error("CO2 latch held through an invalid sample");

    // A latched CO2 exhaust drives the shared exhaust to full.
    a_co2_full_exhaust: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && co2_exhaust_on) |-> (exhaust_demand == FULL_OUT))
        else $error("exhaust not full while CO2 latch is on");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/climate_actuator_demand_controller_top_tb.sv
`default_nettype none

module climate_actuator_demand_controller_top_tb;
    import cadc_pkg::*;

    localparam int FRAC          = 10;
    localparam int FULL          = 1 << FRAC;
    localparam int TEMP_SPAN     = 1024;
    localparam int HUMID_SPAN    = 5120;
    localparam int PHASE_ITEMS   = 125;
    localparam int TAIL_CYCLES   = 16;
    localparam int REPORT_LIMIT  = 10;
    localparam int TIMEOUT_UNITS = 10_000_000;

    // Indexes past the register map; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [15:0] temp_error;
        logic               temp_ok;
        logic signed [15:0] humid_error;
        logic               humid_ok;
        logic signed [15:0] co2_error;
        logic               co2_ok;
    } sample_t;

    typedef struct packed {
        logic [10:0] lamp_demand;
        logic [10:0] mist_demand;
        logic [10:0] exhaust_demand;
        logic        co2_exhaust_on;
    } demand_t;

    typedef struct packed {
        sample_t sample;
        logic    typed;
        demand_t want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic signed [15:0]    temp_error;
    logic                  temp_ok;
    logic signed [15:0]    humid_error;
    logic                  humid_ok;
    logic signed [15:0]    co2_error;
    logic                  co2_ok;
    logic                  out_valid;
    logic                  out_ready;
    logic [10:0]           lamp_demand;
    logic [10:0]           mist_demand;
    logic [10:0]           exhaust_demand;
    logic                  co2_exhaust_on;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Local copy of the register file and the CO2 latch.
    logic [11:0] lamp_gain_set;
    logic [11:0] mist_gain_set;
    logic [11:0] lamp_scale_set;
    logic [11:0] mist_scale_set;
    logic [14:0] co2_on_set;
    logic [14:0] co2_off_set;
    logic        exhaust_latch;

    demand_t pending_demands[$];
    row_t    directed_rows[$];
    int      fail_count;

    climate_actuator_demand_controller_top #(
        .DEMAND_FRAC_BITS (FRAC)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .temp_error     (temp_error),
        .temp_ok        (temp_ok),
        .humid_error    (humid_error),
        .humid_ok       (humid_ok),
        .co2_error      (co2_error),
        .co2_ok         (co2_ok),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lamp_demand    (lamp_demand),
        .mist_demand    (mist_demand),
        .exhaust_demand (exhaust_demand),
        .co2_exhaust_on (co2_exhaust_on),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock, 20 units per period.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Membership of an error in a linear ramp from zero to the span, in Q0.10.
    function automatic int ramp_level(int err, int span);
        if (err <= 0)
            return 0;
        if (err >= span)
            return FULL;
        return (err * FULL) / span;
    endfunction

    // Applies the clamped gain and the scale, then saturates at full demand.
    function automatic logic [10:0] scaled_demand(int level, logic [11:0] gain,
                                                  logic [11:0] scale);
        longint unsigned g;
        longint unsigned p;
        g = (gain < GAIN_LO) ? GAIN_LO : (gain > GAIN_HI) ? GAIN_HI : gain;
        p = (longint'(level) * g * longint'(scale)) >> 16;
        if (p > FULL)
            p = FULL;
        return p[10:0];
    endfunction

    // Works out the demands for one sample and advances the CO2 latch.
    function automatic demand_t predict_demand(sample_t s);
        int      te;
        int      he;
        int      excess;
        int      cold;
        int      hot;
        int      dry;
        int      wet;
        int      notcold;
        int      mist_raw;
        int      hum_exh;
        int      exh_th;
        int      exh_co2;
        demand_t d;
        d = '0;
        exh_th = 0;
        te = $signed(s.temp_error);
        he = $signed(s.humid_error);
        excess = $signed(s.co2_error);
        excess = -excess;

        if (s.temp_ok && s.humid_ok)
        begin
            cold = ramp_level(te, TEMP_SPAN);
            hot = ramp_level(-te, TEMP_SPAN);
            dry = ramp_level(he, HUMID_SPAN);
            wet = ramp_level(-he, HUMID_SPAN);
            notcold = FULL - cold;
            mist_raw = (dry * notcold) >> FRAC;
            hum_exh = (wet * notcold) >> FRAC;
            exh_th = (hot > hum_exh) ? hot : hum_exh;
            d.lamp_demand = scaled_demand(cold, lamp_gain_set, lamp_scale_set);
            d.mist_demand = scaled_demand(mist_raw, mist_gain_set, mist_scale_set);
        end

        // Hysteresis: set above the on threshold, clear below the off threshold.
        if (!s.co2_ok)
            exhaust_latch = 1'b0;
        else if (!exhaust_latch)
        begin
            if (excess > int'(co2_on_set))
                exhaust_latch = 1'b1;
        end
        else if (excess < int'(co2_off_set))
            exhaust_latch = 1'b0;

        exh_co2 = exhaust_latch ? FULL : 0;
        d.exhaust_demand = (exh_th > exh_co2) ? exh_th[10:0] : exh_co2[10:0];
        d.co2_exhaust_on = exhaust_latch;
        return d;
    endfunction

    // Random error: mostly around the ramp, sometimes an edge or any 16 bit value.
    function automatic int pick_error(int span);
        logic [15:0] raw;
        int          reach;
        raw = 16'($urandom);
        reach = span + span / 4;
        case ($urandom_range(0, 9))
            0: return $signed(raw);
            1:
            begin
                case ($urandom_range(0, 5))
                    0: return -32768;
                    1: return 32767;
                    2: return span;
                    3: return -span;
                    4: return span - 1;
                    default: return 1 - span;
                endcase
            end
            default: return int'($urandom_range(0, 2 * reach)) - reach;
        endcase
    endfunction

    // Random sample; the CO2 excess mostly lands near one of the thresholds.
    function automatic sample_t random_sample();
        sample_t     s;
        logic [15:0] raw;
        int          excess;
        raw = 16'($urandom);
        s.temp_error = 16'(pick_error(TEMP_SPAN));
        s.humid_error = 16'(pick_error(HUMID_SPAN));
        s.temp_ok = ($urandom_range(0, 11) != 0);
        s.humid_ok = ($urandom_range(0, 11) != 0);
        s.co2_ok = ($urandom_range(0, 11) != 0);
        case ($urandom_range(0, 7))
            0: excess = -$signed(raw);
            1: excess = int'($urandom_range(0, 400)) - 200;
            2, 3, 4: excess = int'(co2_on_set) + int'($urandom_range(0, 6)) - 3;
            default: excess = int'(co2_off_set) + int'($urandom_range(0, 6)) - 3;
        endcase
        if (excess > 32768)
            excess = 32768;
        if (excess < -32767)
            excess = -32767;
        s.co2_error = 16'(-excess);
        return s;
    endfunction

    function automatic void add_row(int te, int tok, int he, int hok, int ce,
                                    int cok, int typed, int lamp, int mist,
                                    int exh, int on);
        row_t r;
        r.sample.temp_error = te[15:0];
        r.sample.temp_ok = tok[0];
        r.sample.humid_error = he[15:0];
        r.sample.humid_ok = hok[0];
        r.sample.co2_error = ce[15:0];
        r.sample.co2_ok = cok[0];
        r.typed = typed[0];
        r.want.lamp_demand = lamp[10:0];
        r.want.mist_demand = mist[10:0];
        r.want.exhaust_demand = exh[10:0];
        r.want.co2_exhaust_on = on[0];
        directed_rows.push_back(r);
    endfunction

    // Presents one sample beat and holds it until accepted; returns at a falling edge.
    task automatic send_sample(sample_t s, logic typed, demand_t want);
        demand_t got;
        in_valid <= 1'b1;
        temp_error <= s.temp_error;
        temp_ok <= s.temp_ok;
        humid_error <= s.humid_error;
        humid_ok <= s.humid_ok;
        co2_error <= s.co2_error;
        co2_ok <= s.co2_ok;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = predict_demand(s);
        pending_demands.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    // One register write beat; cfg_valid is left high for the caller to lower.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LAMP_GAIN:  lamp_gain_set = data[11:0];
            CFG_MIST_GAIN:  mist_gain_set = data[11:0];
            CFG_LAMP_SCALE: lamp_scale_set = data[11:0];
            CFG_MIST_SCALE: mist_scale_set = data[11:0];
            CFG_CO2_ON:     co2_on_set = data;
            CFG_CO2_OFF:    co2_off_set = data;
            default:        ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_all(logic [14:0] lg, logic [14:0] mg, logic [14:0] ls,
                               logic [14:0] ms, logic [14:0] on, logic [14:0] off);
        write_reg(CFG_LAMP_GAIN, lg);
        write_reg(CFG_MIST_GAIN, mg);
        write_reg(CFG_LAMP_SCALE, ls);
        write_reg(CFG_MIST_SCALE, ms);
        write_reg(CFG_CO2_ON, on);
        write_reg(CFG_CO2_OFF, off);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_demands.size() != 0)
            @(negedge clk);
    endtask

    // Random samples in bursts with random gaps, then a full drain.
    task automatic run_items(int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst)
                send_sample(random_sample(), 1'b0, '0);
            left -= burst;
            if (left > 0 && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat (gap)
                    @(negedge clk);
            end
        end
        in_valid <= 1'b0;
        wait_drained();
    endtask

    // Receiver: stretches of steady ready, hard stalls and random toggling.
    initial
    begin
        int stall_kind;
        int span;
        out_ready = 1'b0;
        forever
        begin
            stall_kind = $urandom_range(0, 3);
            span = $urandom_range(1, 30);
            repeat (span)
            begin
                @(negedge clk);
                case (stall_kind)
                    0, 1:    out_ready <= 1'b1;
                    2:       out_ready <= 1'b0;
                    default: out_ready <= ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    task automatic note_mismatch(string field, int want, int got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    // Each result beat is checked against the oldest pending demand.
    always @(posedge clk)
    begin
        demand_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_demands.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("result beat with nothing pending: lamp %0d mist %0d exh %0d",
                             lamp_demand, mist_demand, exhaust_demand);
            end
            else
            begin
                want = pending_demands.pop_front();
                if (lamp_demand !== want.lamp_demand)
                    note_mismatch("lamp_demand", want.lamp_demand, lamp_demand);
                if (mist_demand !== want.mist_demand)
                    note_mismatch("mist_demand", want.mist_demand, mist_demand);
                if (exhaust_demand !== want.exhaust_demand)
                    note_mismatch("exhaust_demand", want.exhaust_demand, exhaust_demand);
                if (co2_exhaust_on !== want.co2_exhaust_on)
                    note_mismatch("co2_exhaust_on", want.co2_exhaust_on, co2_exhaust_on);
            end
        end
    end

    // Main sequence.
    initial
    begin
        fail_count = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        temp_error = '0;
        temp_ok = 1'b0;
        humid_error = '0;
        humid_ok = 1'b0;
        co2_error = '0;
        co2_ok = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LAMP_GAIN;
        cfg_data = '0;
        lamp_gain_set = 12'd256;
        mist_gain_set = 12'd256;
        lamp_scale_set = 12'd256;
        mist_scale_set = 12'd256;
        co2_on_set = 15'd50;
        co2_off_set = 15'd20;
        exhaust_latch = 1'b0;

        // Directed samples under the reset register values.
        add_row(0, 1, 0, 1, 0, 1, 1, 0, 0, 0, 0);
        add_row(1024, 1, 0, 1, 0, 1, 1, 1024, 0, 0, 0);
        add_row(32767, 1, 32767, 1, 0, 1, 1, 1024, 0, 0, 0);
        add_row(-32768, 1, -32768, 1, 32767, 1, 1, 0, 0, 1024, 0);
        add_row(0, 1, 5120, 1, 0, 1, 1, 0, 1024, 0, 0);
        add_row(-1024, 1, 0, 1, 0, 1, 1, 0, 0, 1024, 0);
        // Either thermal sensor lost zeroes all thermal demands.
        add_row(1024, 0, -5120, 1, 0, 1, 1, 0, 0, 0, 0);
        add_row(-1024, 1, 5120, 0, 0, 1, 1, 0, 0, 0, 0);
        add_row(-32768, 0, -32768, 0, -32768, 0, 1, 0, 0, 0, 0);
        // Points inside the ramps go to the predictor.
        add_row(512, 1, 2560, 1, 0, 1, 0, 0, 0, 0, 0);
        add_row(-300, 1, -1000, 1, 0, 1, 0, 0, 0, 0, 0);
        add_row(1, 1, 1, 1, 0, 1, 0, 0, 0, 0, 0);
        add_row(-1, 1, -1, 1, 0, 1, 0, 0, 0, 0, 0);
        add_row(1023, 1, 5119, 1, 0, 1, 0, 0, 0, 0, 0);
        add_row(-1023, 1, -5119, 1, 0, 1, 0, 0, 0, 0, 0);
        add_row(700, 1, -3000, 1, 0, 1, 0, 0, 0, 0, 0);
        // CO2 latch: thresholds are strict, and a lost sample clears it.
        add_row(0, 1, 0, 1, -50, 1, 1, 0, 0, 0, 0);
        add_row(0, 1, 0, 1, -51, 1, 1, 0, 0, 1024, 1);
        add_row(0, 1, 0, 1, -30, 1, 1, 0, 0, 1024, 1);
        add_row(0, 1, 0, 1, -20, 1, 1, 0, 0, 1024, 1);
        add_row(0, 1, 0, 1, -19, 1, 1, 0, 0, 0, 0);
        add_row(0, 1, 0, 1, -32768, 1, 1, 0, 0, 1024, 1);
        add_row(0, 1, 0, 1, -32768, 0, 1, 0, 0, 0, 0);
        add_row(-1024, 1, 0, 1, -100, 1, 1, 0, 0, 1024, 1);
        add_row(0, 1, 0, 1, 32767, 1, 1, 0, 0, 0, 0);

        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].sample, directed_rows[i].typed,
                        directed_rows[i].want);
        in_valid <= 1'b0;
        wait_drained();

        // Register extremes, gains just outside the clamp, inverted thresholds.
        program_all(15'd0, 15'h7FFF, 15'd4095, 15'd0, 15'd0, 15'd0);
        run_items(PHASE_ITEMS);
        program_all(15'd640, 15'd128, 15'd0, 15'd4095, 15'h7FFF, 15'h7FFF);
        run_items(PHASE_ITEMS);
        program_all(15'd127, 15'd641, 15'd1, 15'd4095, 15'd10, 15'd500);
        run_items(PHASE_ITEMS);
        program_all(15'd4095, 15'd0, 15'd4095, 15'd4095, 15'h7FFF, 15'd0);
        run_items(PHASE_ITEMS);

        // Back to defaults; writes past the map must leave everything alone.
        program_all(15'd256, 15'd256, 15'd256, 15'd256, 15'd50, 15'd20);
        @(negedge clk);
        write_reg(CFG_SPARE_LO, 15'h7FFF);
        write_reg(CFG_SPARE_HI, 15'd0);
        cfg_valid <= 1'b0;
        run_items(PHASE_ITEMS);

        // Random settings, mostly with thresholds small enough to be crossed often.
        repeat (5)
        begin
            program_all(15'($urandom_range(0, 1023)), 15'($urandom_range(0, 1023)),
                        15'($urandom_range(0, 1023)), 15'($urandom_range(0, 1023)),
                        15'(($urandom_range(0, 3) == 0) ? $urandom
                                                        : $urandom_range(0, 400)),
                        15'(($urandom_range(0, 3) == 0) ? $urandom
                                                        : $urandom_range(0, 400)));
            run_items(PHASE_ITEMS);
        end

        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/cadc_pkg.sv
hw/rtl/cadc_cfg.sv
hw/rtl/cadc_mul.sv
hw/rtl/climate_actuator_demand_controller_top.sv
tb/sv/climate_actuator_demand_controller_top_tb.sv
